>>> sv/srev_pkg.sv
// ---------------------------------------------------------------------------
// srev_pkg: shared types and helpers of the stereo comb/allpass reverb
// Holds the register map, the register struct, the line lengths and the
// saturating fixed-point helpers.
// ---------------------------------------------------------------------------
package srev_pkg;

    localparam int COMB_DEPTH_DEF     = 2048;
    localparam int ALLPASS_DEPTH_DEF  = 1024;
    localparam int PREDELAY_DEPTH_DEF = 2048;
    localparam int STEREO_SPREAD_DEF  = 23;

    // register indexes
    typedef enum logic [2:0] {
        REG_DRY      = 3'd0,
        REG_WET      = 3'd1,
        REG_DECAY    = 3'd2,
        REG_DAMPING  = 3'd3,
        REG_DIFFUSE  = 3'd4,
        REG_PREDELAY = 3'd5
    } reg_idx_t;

    localparam logic [8:0]  DRY_RESET      = 9'd256;
    localparam logic [8:0]  WET_RESET      = 9'd128;
    localparam logic [8:0]  DECAY_RESET    = 9'd215;
    localparam logic [8:0]  DAMPING_RESET  = 9'd51;
    localparam logic [8:0]  DIFFUSE_RESET  = 9'd128;
    localparam logic [10:0] PREDELAY_RESET = 11'd1440;

    typedef struct packed {
        logic [8:0]  dry_mix;
        logic [8:0]  wet_mix;
        logic [8:0]  decay;
        logic [8:0]  damping;
        logic [8:0]  diffusion;
        logic [10:0] predelay_samples;
    } cfg_t;

    // base comb lengths
    function automatic logic [10:0] comb_len(input logic [1:0] i);
        logic [10:0] r;
        case (i)
            2'd0:    r = 11'd1116;
            2'd1:    r = 11'd1188;
            2'd2:    r = 11'd1277;
            default: r = 11'd1356;
        endcase
        return r;
    endfunction

    // base allpass lengths
    function automatic logic [10:0] ap_len(input logic i);
        return i ? 11'd441 : 11'd556;
    endfunction

    // gain limited to 256, as a non-negative signed value
    function automatic logic signed [9:0] clamp_gain(input logic [8:0] g);
        return (g > 9'd256) ? 10'sd256 : $signed({1'b0, g});
    endfunction

    // saturate to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [27:0] x);
        logic signed [15:0] r;
        if (x > 28'sd32767) begin
            r = 16'sh7FFF;
        end else if (x < -28'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

    // product with a /256 gain, floor shift
    function automatic logic signed [27:0] mulg(input logic signed [15:0] a,
                                                input logic signed [9:0] g);
        logic signed [27:0] p;
        p = 28'(a) * 28'(g);
        return p >>> 8;
    endfunction

endpackage

>>> sv/stereo_comb_allpass_reverb.sv
// ---------------------------------------------------------------------------
// stereo_comb_allpass_reverb: stereo reverb, predelay, four combs, two allpasses
// Top level with the register file and the processing core.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel takes one stereo sample pair per beat, m_ returns one mixed
//   pair per beat. Registers are written through cfg_we/cfg_addr/cfg_wdata
//   while no sample is in flight.
//   A pair is accepted in the idle state; the sequencer then walks the
//   predelay step, the four comb lines (read, damp, write) and the two
//   allpass lines (read, feedback, output) of the shared memories, and the
//   mix step loads the result into the output register.
//   After reset every delay memory is cleared, one word per cycle, while
//   the clear counter walks all 4*COMB_DEPTH comb words, with s_tready low;
//   register writes are taken meanwhile.
//   When the receiver stalls, the finished pair waits in the output register;
//   the next pair is still accepted and runs until its own mix step, which
//   waits for the register to drain.
// ---------------------------------------------------------------------------
module stereo_comb_allpass_reverb
    import srev_pkg::*;
#(
    parameter int COMB_DEPTH     = COMB_DEPTH_DEF,
    parameter int ALLPASS_DEPTH  = ALLPASS_DEPTH_DEF,
    parameter int PREDELAY_DEPTH = PREDELAY_DEPTH_DEF,
    parameter int STEREO_SPREAD  = STEREO_SPREAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [10:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // left_in [15:0], right_in [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // left_out [15:0], right_out [31:16]
);

    cfg_t cfg_reg;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dry_mix          <= DRY_RESET;
            cfg_reg.wet_mix          <= WET_RESET;
            cfg_reg.decay            <= DECAY_RESET;
            cfg_reg.damping          <= DAMPING_RESET;
            cfg_reg.diffusion        <= DIFFUSE_RESET;
            cfg_reg.predelay_samples <= PREDELAY_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DRY:      cfg_reg.dry_mix          <= cfg_wdata[8:0];
                REG_WET:      cfg_reg.wet_mix          <= cfg_wdata[8:0];
                REG_DECAY:    cfg_reg.decay            <= cfg_wdata[8:0];
                REG_DAMPING:  cfg_reg.damping          <= cfg_wdata[8:0];
                REG_DIFFUSE:  cfg_reg.diffusion        <= cfg_wdata[8:0];
                REG_PREDELAY: cfg_reg.predelay_samples <= cfg_wdata;
                default: ;
            endcase
        end
    end

    srev_core #(
        .COMB_DEPTH     (COMB_DEPTH),
        .ALLPASS_DEPTH  (ALLPASS_DEPTH),
        .PREDELAY_DEPTH (PREDELAY_DEPTH),
        .STEREO_SPREAD  (STEREO_SPREAD)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // one pair at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while busy");

    // nothing comes out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("channel active right after reset");

    // a result needs an accepted pair first: no output during idle wait
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !s_tready || !$past(s_tready))
        else $error("result without work");
`endif

endmodule

>>> sv/srev_core.sv
// ---------------------------------------------------------------------------
// srev_core: delay memories and sequencer of the reverb
// Predelay, comb and allpass memories per channel, read-modify-write by a
// one-hot sequencer, plus the output register.
// ---------------------------------------------------------------------------
module srev_core
    import srev_pkg::*;
#(
    parameter int COMB_DEPTH     = COMB_DEPTH_DEF,
    parameter int ALLPASS_DEPTH  = ALLPASS_DEPTH_DEF,
    parameter int PREDELAY_DEPTH = PREDELAY_DEPTH_DEF,
    parameter int STEREO_SPREAD  = STEREO_SPREAD_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata
);

    localparam int CMW = $clog2(4 * COMB_DEPTH);
    localparam int AMW = $clog2(2 * ALLPASS_DEPTH);
    localparam int PDW = $clog2(PREDELAY_DEPTH);
    localparam int PW  = $clog2(COMB_DEPTH);
    localparam int AW  = $clog2(ALLPASS_DEPTH);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_PRE   = 10'b0000000100,
        ST_CRD   = 10'b0000001000,
        ST_CDMP  = 10'b0000010000,
        ST_CWR   = 10'b0000100000,
        ST_ARD   = 10'b0001000000,
        ST_AF    = 10'b0010000000,
        ST_AO    = 10'b0100000000,
        ST_MIX   = 10'b1000000000
    } state_t;

    state_t state_reg;
    logic [CMW-1:0] clr_reg;
    logic [PDW-1:0] wp_reg;
    logic           zero_dly_reg;
    logic [1:0]     cidx_reg;
    logic           aidx_reg;
    logic [PW-1:0]  cpos_l_reg [4];
    logic [PW-1:0]  cpos_r_reg [4];
    logic [AW-1:0]  apos_l_reg [2];
    logic [AW-1:0]  apos_r_reg [2];
    logic signed [15:0] damp_l_reg [4];
    logic signed [15:0] damp_r_reg [4];
    logic signed [15:0] dry_l_reg, dry_r_reg, wet_l_reg, wet_r_reg;
    logic signed [15:0] d_l_reg, d_r_reg, b_l_reg, b_r_reg, f_l_reg, f_r_reg;
    logic signed [15:0] ap_l_reg, ap_r_reg;
    logic signed [17:0] acc_l_reg, acc_r_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [31:0]        m_data_reg;

    logic signed [15:0] pd_l_mem [PREDELAY_DEPTH];
    logic signed [15:0] pd_r_mem [PREDELAY_DEPTH];
    logic signed [15:0] cm_l_mem [4 * COMB_DEPTH];
    logic signed [15:0] cm_r_mem [4 * COMB_DEPTH];
    logic signed [15:0] ap_l_mem [2 * ALLPASS_DEPTH];
    logic signed [15:0] ap_r_mem [2 * ALLPASS_DEPTH];
    logic signed [15:0] pd_l_rd_reg, pd_r_rd_reg, cm_l_rd_reg, cm_r_rd_reg;
    logic signed [15:0] ap_l_rd_reg, ap_r_rd_reg;

    logic clearing, accept, out_free;
    logic signed [9:0] dry_g, wet_g, dec_g, dmp_g, dif_g, dmp_w;
    logic [13:0] dly, rp_full;
    logic [PDW-1:0] rp, pd_waddr, wp_next;
    logic pd_we;
    logic [CMW-1:0] c_addr_l, c_addr_r, c_waddr_l, c_waddr_r;
    logic cm_we;
    logic signed [15:0] cm_wl, cm_wr;
    logic [AMW-1:0] a_addr_l, a_addr_r, a_waddr_l, a_waddr_r;
    logic ap_we;
    logic signed [15:0] f_l, f_r, ap_wl, ap_wr, d_l, d_r;
    logic [PW:0] clen_l, clen_r, cnx_l, cnx_r;
    logic [AW:0] alen_l, alen_r, anx_l, anx_r;
    logic signed [17:0] acc_l_sum, acc_r_sum;

    assign clearing = (state_reg == ST_CLEAR);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // gains
    assign dry_g = clamp_gain(cfg.dry_mix);
    assign wet_g = clamp_gain(cfg.wet_mix);
    assign dec_g = clamp_gain(cfg.decay);
    assign dmp_g = clamp_gain(cfg.damping);
    assign dif_g = clamp_gain(cfg.diffusion);
    assign dmp_w = 10'sd256 - dmp_g;

    // predelay addressing
    always_comb begin
        dly = (14'(cfg.predelay_samples) >= 14'(PREDELAY_DEPTH)) ?
              14'(PREDELAY_DEPTH - 1) : 14'(cfg.predelay_samples);
        rp_full = (14'(wp_reg) >= dly) ? 14'(wp_reg) - dly
                                       : 14'(wp_reg) + 14'(PREDELAY_DEPTH) - dly;
        rp = rp_full[PDW-1:0];
        wp_next = (wp_reg == PDW'(PREDELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        pd_we = accept || (clearing && (32'(clr_reg) < PREDELAY_DEPTH));
        pd_waddr = clearing ? clr_reg[PDW-1:0] : wp_reg;
    end

    // comb addressing and write-back
    always_comb begin
        c_addr_l = CMW'(cidx_reg) * CMW'(COMB_DEPTH) + CMW'(cpos_l_reg[cidx_reg]);
        c_addr_r = CMW'(cidx_reg) * CMW'(COMB_DEPTH) + CMW'(cpos_r_reg[cidx_reg]);
        cm_we = clearing || (state_reg == ST_CWR);
        c_waddr_l = clearing ? clr_reg : c_addr_l;
        c_waddr_r = clearing ? clr_reg : c_addr_r;
        cm_wl = clearing ? 16'sd0 : sat16(28'(wet_l_reg) + mulg(d_l_reg, dec_g));
        cm_wr = clearing ? 16'sd0 : sat16(28'(wet_r_reg) + mulg(d_r_reg, dec_g));
        d_l = sat16((28'(cm_l_rd_reg) * 28'(dmp_w) + 28'(damp_l_reg[cidx_reg]) *
                     28'(dmp_g)) >>> 8);
        d_r = sat16((28'(cm_r_rd_reg) * 28'(dmp_w) + 28'(damp_r_reg[cidx_reg]) *
                     28'(dmp_g)) >>> 8);
        clen_l = (PW+1)'(comb_len(cidx_reg));
        clen_r = (PW+1)'(comb_len(cidx_reg)) + (PW+1)'(STEREO_SPREAD);
        cnx_l = (PW+1)'(cpos_l_reg[cidx_reg]) + 1'b1;
        cnx_r = (PW+1)'(cpos_r_reg[cidx_reg]) + 1'b1;
        if (cnx_l >= clen_l) cnx_l = '0;
        if (cnx_r >= clen_r) cnx_r = '0;
        acc_l_sum = acc_l_reg + 18'(cm_l_rd_reg);
        acc_r_sum = acc_r_reg + 18'(cm_r_rd_reg);
    end

    // allpass addressing and write-back
    always_comb begin
        a_addr_l = AMW'(aidx_reg) * AMW'(ALLPASS_DEPTH) + AMW'(apos_l_reg[aidx_reg]);
        a_addr_r = AMW'(aidx_reg) * AMW'(ALLPASS_DEPTH) + AMW'(apos_r_reg[aidx_reg]);
        ap_we = (state_reg == ST_AF) ||
                (clearing && (32'(clr_reg) < 2 * ALLPASS_DEPTH));
        a_waddr_l = clearing ? clr_reg[AMW-1:0] : a_addr_l;
        a_waddr_r = clearing ? clr_reg[AMW-1:0] : a_addr_r;
        f_l = sat16(28'(ap_l_reg) + mulg(ap_l_rd_reg, dif_g));
        f_r = sat16(28'(ap_r_reg) + mulg(ap_r_rd_reg, dif_g));
        ap_wl = clearing ? 16'sd0 : f_l;
        ap_wr = clearing ? 16'sd0 : f_r;
        alen_l = (AW+1)'(ap_len(aidx_reg));
        alen_r = (AW+1)'(ap_len(aidx_reg)) + (AW+1)'(STEREO_SPREAD);
        anx_l = (AW+1)'(apos_l_reg[aidx_reg]) + 1'b1;
        anx_r = (AW+1)'(apos_r_reg[aidx_reg]) + 1'b1;
        if (anx_l >= alen_l) anx_l = '0;
        if (anx_r >= alen_r) anx_r = '0;
    end

    // output valid: drained by the receiver, loaded by the mix step
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) m_valid_next = 1'b0;
        if ((state_reg == ST_MIX) && out_free) m_valid_next = 1'b1;
    end

    // predelay memories
    always_ff @(posedge aclk) begin
        if (pd_we) begin
            pd_l_mem[pd_waddr] <= clearing ? 16'sd0 : $signed(s_tdata[15:0]);
            pd_r_mem[pd_waddr] <= clearing ? 16'sd0 : $signed(s_tdata[31:16]);
        end
        pd_l_rd_reg <= pd_l_mem[rp];
        pd_r_rd_reg <= pd_r_mem[rp];
    end

    // comb memories
    always_ff @(posedge aclk) begin
        if (cm_we) begin
            cm_l_mem[c_waddr_l] <= cm_wl;
            cm_r_mem[c_waddr_r] <= cm_wr;
        end
        cm_l_rd_reg <= cm_l_mem[c_addr_l];
        cm_r_rd_reg <= cm_r_mem[c_addr_r];
    end

    // allpass memories
    always_ff @(posedge aclk) begin
        if (ap_we) begin
            ap_l_mem[a_waddr_l] <= ap_wl;
            ap_r_mem[a_waddr_r] <= ap_wr;
        end
        ap_l_rd_reg <= ap_l_mem[a_addr_l];
        ap_r_rd_reg <= ap_r_mem[a_addr_r];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            wp_reg      <= '0;
            cidx_reg    <= '0;
            aidx_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                cpos_l_reg[i] <= '0;
                cpos_r_reg[i] <= '0;
                damp_l_reg[i] <= '0;
                damp_r_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                apos_l_reg[i] <= '0;
                apos_r_reg[i] <= '0;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == CMW'(4 * COMB_DEPTH - 1)) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (accept) begin
                        dry_l_reg    <= $signed(s_tdata[15:0]);
                        dry_r_reg    <= $signed(s_tdata[31:16]);
                        zero_dly_reg <= (dly == 14'd0);
                        wp_reg       <= wp_next;
                        state_reg    <= ST_PRE;
                    end
                end
                ST_PRE: begin
                    wet_l_reg <= zero_dly_reg ? dry_l_reg : pd_l_rd_reg;
                    wet_r_reg <= zero_dly_reg ? dry_r_reg : pd_r_rd_reg;
                    acc_l_reg <= '0;
                    acc_r_reg <= '0;
                    cidx_reg  <= '0;
                    state_reg <= ST_CRD;
                end
                ST_CRD: state_reg <= ST_CDMP;
                ST_CDMP: begin
                    d_l_reg <= d_l;
                    d_r_reg <= d_r;
                    damp_l_reg[cidx_reg] <= d_l;
                    damp_r_reg[cidx_reg] <= d_r;
                    acc_l_reg <= acc_l_sum;
                    acc_r_reg <= acc_r_sum;
                    state_reg <= ST_CWR;
                end
                ST_CWR: begin
                    cpos_l_reg[cidx_reg] <= cnx_l[PW-1:0];
                    cpos_r_reg[cidx_reg] <= cnx_r[PW-1:0];
                    if (cidx_reg == 2'd3) begin
                        // divide by four, truncating toward zero
                        ap_l_reg  <= 16'((acc_l_reg + (acc_l_reg[17] ? 18'sd3 : 18'sd0)) >>> 2);
                        ap_r_reg  <= 16'((acc_r_reg + (acc_r_reg[17] ? 18'sd3 : 18'sd0)) >>> 2);
                        aidx_reg  <= 1'b0;
                        state_reg <= ST_ARD;
                    end else begin
                        cidx_reg  <= cidx_reg + 1'b1;
                        state_reg <= ST_CRD;
                    end
                end
                ST_ARD: state_reg <= ST_AF;
                ST_AF: begin
                    b_l_reg   <= ap_l_rd_reg;
                    b_r_reg   <= ap_r_rd_reg;
                    f_l_reg   <= f_l;
                    f_r_reg   <= f_r;
                    state_reg <= ST_AO;
                end
                ST_AO: begin
                    ap_l_reg <= sat16(28'(b_l_reg) - mulg(f_l_reg, dif_g));
                    ap_r_reg <= sat16(28'(b_r_reg) - mulg(f_r_reg, dif_g));
                    apos_l_reg[aidx_reg] <= anx_l[AW-1:0];
                    apos_r_reg[aidx_reg] <= anx_r[AW-1:0];
                    if (aidx_reg) begin
                        state_reg <= ST_MIX;
                    end else begin
                        aidx_reg  <= 1'b1;
                        state_reg <= ST_ARD;
                    end
                end
                ST_MIX: begin
                    if (out_free) begin
                        m_data_reg[15:0]  <= sat16(mulg(dry_l_reg, dry_g) +
                                                   mulg(ap_l_reg, wet_g));
                        m_data_reg[31:16] <= sat16(mulg(dry_r_reg, dry_g) +
                                                   mulg(ap_r_reg, wet_g));
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
